// ===== src/erc_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Elevation rate command package
// Shared types, register indexes, reset values and widths for the elevation
// rate request block.
// ----------------------------------------------------------------------------
package erc_pkg;

    localparam int CfgAddrW = 3;
    localparam int CfgDataW = 23;
    localparam int OutW     = 24;

    // Register indexes of the configuration port
    typedef enum logic [CfgAddrW-1:0] {
        CFG_GYRO_SCALE      = 3'd0,
        CFG_ELEV_LOW_LIMIT  = 3'd1,
        CFG_ELEV_HIGH_LIMIT = 3'd2,
        CFG_RECOVERY_RATE   = 3'd3,
        CFG_SPEED_LIMIT     = 3'd4,
        CFG_STEP_LIMIT      = 3'd5,
        CFG_POSITION_GAIN   = 3'd6,
        CFG_LOCK_GAIN       = 3'd7
    } t_cfg_addr;

    typedef enum logic [1:0] {
        MODE_VELOCITY = 2'd0,
        MODE_POSITION = 2'd1,
        MODE_LOCK     = 2'd2,
        MODE_NONE     = 2'd3
    } t_axis_mode;

    localparam logic [15:0] RST_GYRO_SCALE      = 16'd256;
    localparam logic [22:0] RST_ELEV_LOW_LIMIT  = 23'd1310720;
    localparam logic [22:0] RST_ELEV_HIGH_LIMIT = 23'd4259840;
    localparam logic [19:0] RST_RECOVERY_RATE   = 20'd13107;
    localparam logic [19:0] RST_SPEED_LIMIT     = 20'd32768;
    localparam logic [19:0] RST_STEP_LIMIT      = 20'd5120;
    localparam logic [15:0] RST_POSITION_GAIN   = 16'd23593;
    localparam logic [15:0] RST_LOCK_GAIN       = 16'd41943;

    localparam logic signed [OutW:0] OUT_MAX = 25'sd8388607;
    localparam logic signed [OutW:0] OUT_MIN = -25'sd8388608;

    typedef struct packed {
        logic [15:0] gyro_scale;
        logic [22:0] elev_low_limit;
        logic [22:0] elev_high_limit;
        logic [19:0] recovery_rate;
        logic [19:0] speed_limit;
        logic [19:0] step_limit;
        logic [15:0] position_gain;
        logic [15:0] lock_gain;
    } t_erc_cfg;

    // Classified request passed from the front end to the back end
    typedef struct packed {
        logic signed [32:0] base_rate;
        logic signed [32:0] correction;
        logic               low_trip;
        logic               high_trip;
    } t_erc_job;

endpackage
`default_nettype wire

// ===== src/erc_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Elevation rate command front end
// Takes requests, selects the base rate by axis mode (gain product where
// needed), forms the gyro correction and flags the elevation limits.
// ----------------------------------------------------------------------------
module erc_front (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  erc_pkg::t_erc_cfg       i_cfg,
    input  wire                     push,
    output logic                    full,
    input  wire  [1:0]              i_axis_mode,
    input  wire  signed [31:0]      i_commanded_rate,
    input  wire  signed [25:0]      i_target_elevation,
    input  wire  signed [25:0]      i_estimated_elevation,
    input  wire  signed [25:0]      i_encoder_elevation,
    input  wire  signed [31:0]      i_gyro_offset,
    input  wire  signed [31:0]      i_gyro_earth_rate,
    output logic                    o_job_push,
    input  wire                     i_job_full,
    output erc_pkg::t_erc_job       o_job
);
    import erc_pkg::*;

    logic               r_valid;
    t_axis_mode         r_mode;
    logic signed [31:0] r_cmd;
    logic signed [25:0] r_target;
    logic signed [25:0] r_est;
    logic signed [25:0] r_enc;
    logic signed [31:0] r_offs;
    logic signed [31:0] r_earth;

    logic               w_accept;
    logic signed [26:0] w_diff;
    logic        [15:0] w_gain;
    logic signed [43:0] w_prod;
    logic signed [26:0] w_enc_x;

    assign full       = r_valid && i_job_full;
    assign w_accept   = push && !full;
    assign o_job_push = r_valid && !i_job_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_mode  <= MODE_NONE;
        end else if (w_accept) begin
            r_valid <= 1'b1;
            r_mode  <= t_axis_mode'(i_axis_mode);
        end else if (o_job_push) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cmd    <= i_commanded_rate;
            r_target <= i_target_elevation;
            r_est    <= i_estimated_elevation;
            r_enc    <= i_encoder_elevation;
            r_offs   <= i_gyro_offset;
            r_earth  <= i_gyro_earth_rate;
        end
    end

    // Lock mode tracks the encoder, position mode the pointing solution
    always_comb begin
        if (r_mode == MODE_POSITION) begin
            w_diff = {r_target[25], r_target} - {r_est[25], r_est};
            w_gain = i_cfg.position_gain;
        end else begin
            w_diff = {r_target[25], r_target} - {r_enc[25], r_enc};
            w_gain = i_cfg.lock_gain;
        end
    end

    assign w_prod  = w_diff * $signed({1'b0, w_gain});
    assign w_enc_x = {r_enc[25], r_enc};

    always_comb begin
        o_job = '0;
        unique case (r_mode)
            MODE_VELOCITY: o_job.base_rate = {r_cmd[31], r_cmd};
            MODE_POSITION,
            MODE_LOCK:     o_job.base_rate = {{5{w_prod[43]}}, w_prod[43:16]};
            MODE_NONE:     o_job.base_rate = '0;
        endcase
        o_job.correction = {r_offs[31], r_offs} - {r_earth[31], r_earth};
        o_job.low_trip   = w_enc_x < $signed({4'b0, i_cfg.elev_low_limit});
        o_job.high_trip  = w_enc_x > $signed({4'b0, i_cfg.elev_high_limit});
    end

endmodule
`default_nettype wire

// ===== src/erc_queue.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Elevation rate command job queue
// Two-entry queue of classified requests between front end and back end.
// ----------------------------------------------------------------------------
module erc_queue (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_push,
    input  erc_pkg::t_erc_job   i_data,
    output logic                o_full,
    input  wire                 i_pop,
    output logic                o_empty,
    output erc_pkg::t_erc_job   o_data
);
    import erc_pkg::*;

    t_erc_job    r_mem [2];
    logic        r_wr_ptr;
    logic        r_rd_ptr;
    logic [1:0]  r_count;
    logic        w_wr;
    logic        w_rd;

    assign o_full  = r_count == 2'd2;
    assign o_empty = r_count == 2'd0;
    assign w_wr    = i_push && !o_full;
    assign w_rd    = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (w_wr) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (w_rd) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            if (w_wr && !w_rd) begin
                r_count <= r_count + 2'd1;
            end else if (w_rd && !w_wr) begin
                r_count <= r_count - 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule
`default_nettype wire

// ===== src/erc_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Elevation rate command back end
// Applies correction, limit recovery and speed clamp, scales to gyro units,
// limits the step against the last output and saturates.
// ----------------------------------------------------------------------------
module erc_back (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  erc_pkg::t_erc_cfg   i_cfg,
    input  wire                 i_job_empty,
    output logic                o_job_pop,
    input  erc_pkg::t_erc_job   i_job,
    output logic                empty,
    input  wire                 pop,
    output logic signed [23:0]  o_rate_command
);
    import erc_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_MUL  = 3'b010,
        S_STEP = 3'b100
    } t_back_state;

    t_back_state        r_state;
    t_back_state        n_state;
    logic signed [20:0] r_clamp;
    logic signed [21:0] r_scaled;
    logic signed [23:0] r_prev;
    logic               r_out_valid;
    logic signed [23:0] r_out;

    logic signed [33:0] w_rate;
    logic signed [33:0] w_lim;
    logic signed [33:0] w_rec;
    logic signed [20:0] w_clamp;
    logic signed [37:0] w_prod;
    logic signed [24:0] w_v;
    logic signed [24:0] w_prev;
    logic signed [24:0] w_step;
    logic signed [24:0] w_diff;
    logic signed [24:0] w_lim_v;
    logic signed [23:0] w_sat;
    logic               w_out_free;
    logic               w_finish;

    assign empty          = !r_out_valid;
    assign o_rate_command = r_out;
    assign w_out_free     = !r_out_valid || pop;
    assign o_job_pop      = (r_state == S_IDLE) && !i_job_empty;
    assign w_finish       = (r_state == S_STEP) && w_out_free;

    // Correct, override outside the elevation limits (downward wins), clamp
    always_comb begin
        w_lim  = $signed({14'b0, i_cfg.speed_limit});
        w_rec  = $signed({14'b0, i_cfg.recovery_rate});
        w_rate = {i_job.base_rate[32], i_job.base_rate}
               - {i_job.correction[32], i_job.correction};
        if (i_job.high_trip) begin
            w_rate = -w_rec;
        end else if (i_job.low_trip) begin
            w_rate = w_rec;
        end
        if (w_rate > w_lim) begin
            w_rate = w_lim;
        end else if (w_rate < -w_lim) begin
            w_rate = -w_lim;
        end
        w_clamp = w_rate[20:0];
    end

    assign w_prod = r_clamp * $signed({1'b0, i_cfg.gyro_scale});

    always_comb begin
        w_v     = {{3{r_scaled[21]}}, r_scaled};
        w_prev  = {r_prev[23], r_prev};
        w_step  = $signed({5'b0, i_cfg.step_limit});
        w_diff  = w_v - w_prev;
        w_lim_v = w_v;
        if (w_diff > w_step) begin
            w_lim_v = w_prev + w_step;
        end else if (w_diff < -w_step) begin
            w_lim_v = w_prev - w_step;
        end
        if (w_lim_v > OUT_MAX) begin
            w_sat = OUT_MAX[23:0];
        end else if (w_lim_v < OUT_MIN) begin
            w_sat = OUT_MIN[23:0];
        end else begin
            w_sat = w_lim_v[23:0];
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (!i_job_empty) n_state = S_MUL;
            S_MUL:  n_state = S_STEP;
            S_STEP: if (w_out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_prev      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_finish) begin
                r_prev      <= w_sat;
                r_out_valid <= 1'b1;
            end else if (pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_job_pop) begin
            r_clamp <= w_clamp;
        end
        if (r_state == S_MUL) begin
            // floor by arithmetic shift
            r_scaled <= w_prod[37:16];
        end
        if (w_finish) begin
            r_out <= w_sat;
        end
    end

endmodule
`default_nettype wire

// ===== src/elevation_rate_command.sv =====
`default_nettype none
// An accepted request is held in the front-end register, then written to
// the queue, then taken through 3 back-end steps: combine/clamp, scale
// multiply, step limit. The back end works on one request at a time.
// Reset: synchronous, active low; clears queues, the last output and loads
// the default register values.
// ----------------------------------------------------------------------------
// Elevation rate command
// Builds the elevation servo rate request from mode, targets and gyro terms.
// ----------------------------------------------------------------------------
module elevation_rate_command (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    input  wire                            i_cfg_wr_en,
    input  wire  [erc_pkg::CfgAddrW-1:0]   i_cfg_addr,
    input  wire  [erc_pkg::CfgDataW-1:0]   i_cfg_wdata,
    input  wire                            push,
    output logic                           full,
    input  wire  [1:0]                     i_axis_mode,
    input  wire  signed [31:0]             i_commanded_rate,
    input  wire  signed [25:0]             i_target_elevation,
    input  wire  signed [25:0]             i_estimated_elevation,
    input  wire  signed [25:0]             i_encoder_elevation,
    input  wire  signed [31:0]             i_gyro_offset,
    input  wire  signed [31:0]             i_gyro_earth_rate,
    output logic                           empty,
    input  wire                            pop,
    output logic signed [23:0]             o_rate_command
);
    import erc_pkg::*;

    t_erc_cfg r_cfg;
    t_erc_job w_front_job;
    t_erc_job w_back_job;
    logic     w_job_push;
    logic     w_job_full;
    logic     w_job_pop;
    logic     w_job_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.gyro_scale      <= RST_GYRO_SCALE;
            r_cfg.elev_low_limit  <= RST_ELEV_LOW_LIMIT;
            r_cfg.elev_high_limit <= RST_ELEV_HIGH_LIMIT;
            r_cfg.recovery_rate   <= RST_RECOVERY_RATE;
            r_cfg.speed_limit     <= RST_SPEED_LIMIT;
            r_cfg.step_limit      <= RST_STEP_LIMIT;
            r_cfg.position_gain   <= RST_POSITION_GAIN;
            r_cfg.lock_gain       <= RST_LOCK_GAIN;
        end else if (i_cfg_wr_en) begin
            unique case (t_cfg_addr'(i_cfg_addr))
                CFG_GYRO_SCALE:      r_cfg.gyro_scale      <= i_cfg_wdata[15:0];
                CFG_ELEV_LOW_LIMIT:  r_cfg.elev_low_limit  <= i_cfg_wdata;
                CFG_ELEV_HIGH_LIMIT: r_cfg.elev_high_limit <= i_cfg_wdata;
                CFG_RECOVERY_RATE:   r_cfg.recovery_rate   <= i_cfg_wdata[19:0];
                CFG_SPEED_LIMIT:     r_cfg.speed_limit     <= i_cfg_wdata[19:0];
                CFG_STEP_LIMIT:      r_cfg.step_limit      <= i_cfg_wdata[19:0];
                CFG_POSITION_GAIN:   r_cfg.position_gain   <= i_cfg_wdata[15:0];
                CFG_LOCK_GAIN:       r_cfg.lock_gain       <= i_cfg_wdata[15:0];
            endcase
        end
    end

    erc_front u_front (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .i_cfg                 (r_cfg),
        .push                  (push),
        .full                  (full),
        .i_axis_mode           (i_axis_mode),
        .i_commanded_rate      (i_commanded_rate),
        .i_target_elevation    (i_target_elevation),
        .i_estimated_elevation (i_estimated_elevation),
        .i_encoder_elevation   (i_encoder_elevation),
        .i_gyro_offset         (i_gyro_offset),
        .i_gyro_earth_rate     (i_gyro_earth_rate),
        .o_job_push            (w_job_push),
        .i_job_full            (w_job_full),
        .o_job                 (w_front_job)
    );

    erc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_job_push),
        .i_data  (w_front_job),
        .o_full  (w_job_full),
        .i_pop   (w_job_pop),
        .o_empty (w_job_empty),
        .o_data  (w_back_job)
    );

    erc_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (r_cfg),
        .i_job_empty    (w_job_empty),
        .o_job_pop      (w_job_pop),
        .i_job          (w_back_job),
        .empty          (empty),
        .pop            (pop),
        .o_rate_command (o_rate_command)
    );

endmodule
`default_nettype wire
